FILE: src/track_cluster_match_score_core_defines.svh
`ifndef TRACK_CLUSTER_MATCH_SCORE_CORE_DEFINES_SVH
`define TRACK_CLUSTER_MATCH_SCORE_CORE_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define TCMS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked while out of reset
`define TCMS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/tcms_pkg.sv
package tcms_pkg;

	localparam int POS_W  = 16;
	localparam int AREA_W = 20;
	localparam int ANG_W  = 16;
	localparam int FAC_W  = 16;
	localparam int DIST_W = 16;

	localparam int DIFF_W = POS_W + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int LEN_W  = 2 * POS_W + 1;
	localparam int X_W    = 2 * DIFF_W;
	localparam int HALF_W = X_W / 2;
	localparam int ROOT_W = 70;
	localparam int REM_W  = AREA_W + FAC_W + 1;

	localparam int GEO_LAT  = 5;
	localparam int ROOT_LAT = DIST_W;
	localparam int DIV_LAT  = FAC_W;
	localparam int AREA_LAT = DIV_LAT + 1;
	localparam int ANG_LAT  = 3;
	localparam int CORE_LAT = GEO_LAT + ROOT_LAT;

	localparam logic [FAC_W-1:0] ONE_Q15 = 16'h8000;

	localparam int TURN_W = ANG_W + 2;
	localparam logic signed [TURN_W-1:0] FULL_TURN = 18'sd46080;
	localparam logic signed [TURN_W-1:0] HALF_TURN = 18'sd23040;

	// floor(x / 90) as (x * RECIP_90) >> RECIP_SH, exact for x below 1636800
	localparam int GF_W = 21;
	localparam logic [GF_W-1:0] RECIP_90 = 21'd1491309;
	localparam int RECIP_SH = 27;

	typedef struct packed {
		logic [ROOT_W-1:0] target;
		logic [LEN_W-1:0]  len2;
	} root_req_t;

endpackage

FILE: src/tcms_geom.sv
module tcms_geom (
	input  logic                         clk,
	input  logic                         en,
	input  logic [tcms_pkg::POS_W-1:0]   cluster_x,
	input  logic [tcms_pkg::POS_W-1:0]   cluster_y,
	input  logic [tcms_pkg::POS_W-1:0]   track_x,
	input  logic [tcms_pkg::POS_W-1:0]   track_y,
	input  logic [tcms_pkg::POS_W-1:0]   predicted_x,
	input  logic [tcms_pkg::POS_W-1:0]   predicted_y,
	output tcms_pkg::root_req_t          req
);
	import tcms_pkg::*;

	logic signed [DIFF_W-1:0] dx_s1, dy_s1, rx_s1, ry_s1, qx_s1, qy_s1;
	logic signed [PROD_W-1:0] dxx_s2, dyy_s2, rxdx_s2, rydy_s2, dxry_s2, dyrx_s2;
	logic signed [PROD_W-1:0] rxx_s2, ryy_s2, qxx_s2, qyy_s2;
	logic [LEN_W-1:0]         len2_c, send_c, eend_c, smin_c;
	logic signed [PROD_W:0]   dot_c, cross_c, ndot_c;
	logic                     perp_c;
	logic [X_W-1:0]           xabs_c;
	logic [LEN_W-1:0]         len2_s3, smin_s3;
	logic [X_W-1:0]           xabs_s3;
	logic                     perp_s3;
	logic [PROD_W-1:0]        hh_s4, hl_s4, ll_s4;
	logic [LEN_W-1:0]         l_s4, smin_s4;
	logic                     perp_s4;
	root_req_t                req_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= $signed({1'b0, predicted_x}) - $signed({1'b0, track_x});
			dy_s1 <= $signed({1'b0, predicted_y}) - $signed({1'b0, track_y});
			rx_s1 <= $signed({1'b0, track_x}) - $signed({1'b0, cluster_x});
			ry_s1 <= $signed({1'b0, track_y}) - $signed({1'b0, cluster_y});
			qx_s1 <= $signed({1'b0, predicted_x}) - $signed({1'b0, cluster_x});
			qy_s1 <= $signed({1'b0, predicted_y}) - $signed({1'b0, cluster_y});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dxx_s2  <= dx_s1 * dx_s1;
			dyy_s2  <= dy_s1 * dy_s1;
			rxdx_s2 <= rx_s1 * dx_s1;
			rydy_s2 <= ry_s1 * dy_s1;
			dxry_s2 <= dx_s1 * ry_s1;
			dyrx_s2 <= dy_s1 * rx_s1;
			rxx_s2  <= rx_s1 * rx_s1;
			ryy_s2  <= ry_s1 * ry_s1;
			qxx_s2  <= qx_s1 * qx_s1;
			qyy_s2  <= qy_s1 * qy_s1;
		end
	end

	always_comb begin
		len2_c  = LEN_W'(dxx_s2 + dyy_s2);
		send_c  = LEN_W'(rxx_s2 + ryy_s2);
		eend_c  = LEN_W'(qxx_s2 + qyy_s2);
		smin_c  = (send_c < eend_c) ? send_c : eend_c;
		dot_c   = (PROD_W+1)'(rxdx_s2) + (PROD_W+1)'(rydy_s2);
		cross_c = (PROD_W+1)'(dxry_s2) - (PROD_W+1)'(dyrx_s2);
		ndot_c  = -dot_c;
		// projection inside the segment, zero-length segment excluded
		perp_c  = (len2_c != '0) && (dot_c <= 0) &&
			(ndot_c <= $signed({2'b00, len2_c}));
		xabs_c  = cross_c[PROD_W] ? X_W'(-cross_c) : X_W'(cross_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len2_s3 <= len2_c;
			smin_s3 <= smin_c;
			xabs_s3 <= xabs_c;
			perp_s3 <= perp_c;
		end
	end

	// square of the cross product split into halves
	always_ff @(posedge clk) begin
		if (en) begin
			hh_s4   <= xabs_s3[X_W-1:HALF_W] * xabs_s3[X_W-1:HALF_W];
			hl_s4   <= xabs_s3[X_W-1:HALF_W] * xabs_s3[HALF_W-1:0];
			ll_s4   <= xabs_s3[HALF_W-1:0] * xabs_s3[HALF_W-1:0];
			l_s4    <= perp_s3 ? len2_s3 : LEN_W'(1);
			smin_s4 <= smin_s3;
			perp_s4 <= perp_s3;
		end
	end

	// the middle term appears twice in the square
	always_ff @(posedge clk) begin
		if (en) begin
			req_s5.len2 <= l_s4;
			if (perp_s4) begin
				req_s5.target <= (ROOT_W'(hh_s4) << (2 * HALF_W + 2)) +
					(ROOT_W'(hl_s4) << (HALF_W + 3)) + (ROOT_W'(ll_s4) << 2);
			end else begin
				req_s5.target <= ROOT_W'(smin_s4) << 2;
			end
		end
	end

	assign req = req_s5;

endmodule

FILE: src/tcms_root.sv
module tcms_root (
	input  logic                         clk,
	input  logic                         en,
	input  tcms_pkg::root_req_t          req,
	output logic [tcms_pkg::DIST_W-1:0]  distance
);
	import tcms_pkg::*;

	// one result bit per stage: keeps n^2*L and n*L so the trial needs only adds
	logic [DIST_W-1:0] n_s [ROOT_LAT];
	logic [ROOT_W-1:0] p_s [ROOT_LAT];
	logic [ROOT_W-1:0] q_s [ROOT_LAT];
	logic [LEN_W-1:0]  l_s [ROOT_LAT];
	logic [ROOT_W-1:0] t_s [ROOT_LAT];

	logic [DIST_W-1:0] n_in  [ROOT_LAT];
	logic [ROOT_W-1:0] p_in  [ROOT_LAT];
	logic [ROOT_W-1:0] q_in  [ROOT_LAT];
	logic [LEN_W-1:0]  l_in  [ROOT_LAT];
	logic [ROOT_W-1:0] t_in  [ROOT_LAT];
	logic [DIST_W-1:0] n_try [ROOT_LAT];
	logic [ROOT_W-1:0] p_try [ROOT_LAT];
	logic [ROOT_W-1:0] q_try [ROOT_LAT];
	logic              fit   [ROOT_LAT];

	always_comb begin
		for (int g = 0; g < ROOT_LAT; g++) begin
			if (g == 0) begin
				n_in[g] = '0;
				p_in[g] = '0;
				q_in[g] = '0;
				l_in[g] = req.len2;
				t_in[g] = req.target;
			end else begin
				n_in[g] = n_s[g-1];
				p_in[g] = p_s[g-1];
				q_in[g] = q_s[g-1];
				l_in[g] = l_s[g-1];
				t_in[g] = t_s[g-1];
			end
			n_try[g] = n_in[g] | (DIST_W'(1) << (DIST_W - 1 - g));
			p_try[g] = p_in[g] + (q_in[g] << (DIST_W - g)) +
				(ROOT_W'(l_in[g]) << (2 * (DIST_W - 1 - g)));
			q_try[g] = q_in[g] + (ROOT_W'(l_in[g]) << (DIST_W - 1 - g));
			// (2n-1)^2 * L against the target
			fit[g] = ((p_try[g] << 2) - (q_try[g] << 2) + ROOT_W'(l_in[g])) <= t_in[g];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < ROOT_LAT; g++) begin
				n_s[g] <= fit[g] ? n_try[g] : n_in[g];
				p_s[g] <= fit[g] ? p_try[g] : p_in[g];
				q_s[g] <= fit[g] ? q_try[g] : q_in[g];
				l_s[g] <= l_in[g];
				t_s[g] <= t_in[g];
			end
		end
	end

	assign distance = n_s[ROOT_LAT-1];

endmodule

FILE: src/tcms_area.sv
module tcms_area (
	input  logic                         clk,
	input  logic                         en,
	input  logic [tcms_pkg::AREA_W-1:0]  cluster_area,
	input  logic [tcms_pkg::AREA_W-1:0]  track_mean_area,
	output logic [tcms_pkg::AREA_W-1:0]  area_dif,
	output logic [tcms_pkg::FAC_W-1:0]   area_factor
);
	import tcms_pkg::*;

	logic [AREA_W-1:0] adif_c, base_c;
	logic [AREA_W-1:0] adif_s1;
	logic [REM_W-1:0]  rem_s1;
	logic [AREA_W:0]   den_s1;
	logic              zero_s1, sat_s1;

	logic [REM_W-1:0]  rem_s  [DIV_LAT];
	logic [FAC_W-1:0]  quo_s  [DIV_LAT];
	logic [AREA_W:0]   den_s  [DIV_LAT];
	logic [AREA_W-1:0] adif_s [DIV_LAT];
	logic              zero_s [DIV_LAT];
	logic              sat_s  [DIV_LAT];

	logic [REM_W-1:0]  rem_in [DIV_LAT];
	logic [FAC_W-1:0]  quo_in [DIV_LAT];
	logic [AREA_W:0]   den_in [DIV_LAT];
	logic [AREA_W-1:0] adif_in [DIV_LAT];
	logic              zero_in [DIV_LAT];
	logic              sat_in [DIV_LAT];
	logic [REM_W-1:0]  sub_c  [DIV_LAT];

	always_comb begin
		adif_c = (cluster_area > track_mean_area) ? cluster_area - track_mean_area :
			track_mean_area - cluster_area;
		base_c = (track_mean_area != '0) ? track_mean_area : cluster_area;
	end

	// numerator carries the rounding half: ((a - dif) * 2^16 + a) / (2a)
	always_ff @(posedge clk) begin
		if (en) begin
			adif_s1 <= adif_c;
			zero_s1 <= (base_c == '0);
			sat_s1  <= (adif_c >= base_c);
			den_s1  <= {base_c, 1'b0};
			if (adif_c < base_c) begin
				rem_s1 <= (REM_W'(base_c - adif_c) << FAC_W) + REM_W'(base_c);
			end else begin
				rem_s1 <= '0;
			end
		end
	end

	always_comb begin
		for (int g = 0; g < DIV_LAT; g++) begin
			if (g == 0) begin
				rem_in[g]  = rem_s1;
				quo_in[g]  = '0;
				den_in[g]  = den_s1;
				adif_in[g] = adif_s1;
				zero_in[g] = zero_s1;
				sat_in[g]  = sat_s1;
			end else begin
				rem_in[g]  = rem_s[g-1];
				quo_in[g]  = quo_s[g-1];
				den_in[g]  = den_s[g-1];
				adif_in[g] = adif_s[g-1];
				zero_in[g] = zero_s[g-1];
				sat_in[g]  = sat_s[g-1];
			end
			sub_c[g] = REM_W'(den_in[g]) << (DIV_LAT - 1 - g);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < DIV_LAT; g++) begin
				if (rem_in[g] >= sub_c[g]) begin
					rem_s[g] <= rem_in[g] - sub_c[g];
					quo_s[g] <= quo_in[g] | (FAC_W'(1) << (DIV_LAT - 1 - g));
				end else begin
					rem_s[g] <= rem_in[g];
					quo_s[g] <= quo_in[g];
				end
				den_s[g]  <= den_in[g];
				adif_s[g] <= adif_in[g];
				zero_s[g] <= zero_in[g];
				sat_s[g]  <= sat_in[g];
			end
		end
	end

	always_comb begin
		area_dif = adif_s[DIV_LAT-1];
		if (zero_s[DIV_LAT-1]) begin
			area_factor = ONE_Q15;
		end else if (sat_s[DIV_LAT-1]) begin
			area_factor = '0;
		end else begin
			area_factor = quo_s[DIV_LAT-1];
		end
	end

endmodule

FILE: src/tcms_angle.sv
module tcms_angle (
	input  logic                                clk,
	input  logic                                en,
	input  logic [tcms_pkg::ANG_W-1:0]          cluster_angle,
	input  logic [tcms_pkg::ANG_W-1:0]          track_angle,
	output logic signed [tcms_pkg::ANG_W-1:0]   angle_dif,
	output logic [tcms_pkg::FAC_W-1:0]          angle_factor
);
	import tcms_pkg::*;

	localparam int MAG_SH = 6;
	localparam logic [GF_W-1:0] HALF_90 = 21'd45;

	logic signed [TURN_W-1:0] dif_s1, wrap_c, mag_c;
	logic signed [ANG_W-1:0]  dif_s2, dif_s3;
	logic [GF_W-1:0]          x_s2;
	logic [2*GF_W-1:0]        prod_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			dif_s1 <= $signed({2'b00, cluster_angle}) - $signed({2'b00, track_angle});
		end
	end

	// one turn added or taken away is enough for any input pair
	always_comb begin
		if (dif_s1 < -HALF_TURN) begin
			wrap_c = dif_s1 + FULL_TURN;
		end else if (dif_s1 > HALF_TURN) begin
			wrap_c = dif_s1 - FULL_TURN;
		end else begin
			wrap_c = dif_s1;
		end
		mag_c = wrap_c[TURN_W-1] ? -wrap_c : wrap_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dif_s2 <= ANG_W'(wrap_c);
			x_s2   <= (GF_W'(mag_c) << MAG_SH) + HALF_90;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= x_s2 * RECIP_90;
			dif_s3  <= dif_s2;
		end
	end

	assign angle_dif    = dif_s3;
	assign angle_factor = ONE_Q15 - FAC_W'(prod_s3 >> RECIP_SH);

endmodule

FILE: src/track_cluster_match_score_core.sv
// Match measures for one cluster/track pair per request.
// Input channel: in_valid / in_stall with the ten cluster and track fields.
// A request is taken at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with segment distance, area difference,
// area factor, angle difference and angle factor of that request.
// The segment distance path is the longest: 5 stages of differences, products
// and sums, then 16 stages of a bit-per-stage square root. The area divider
// (17 stages) and the angle path (3 stages) are delayed to line up with it.
// Throughput is one request per cycle while the output does not stall; requests keep their order.
// While out_valid is high and out_stall is high the whole pipeline holds and
// in_stall is raised; nothing is lost or repeated.
// Reset (arst_n low) empties the pipeline; out_valid goes low at once.
`include "track_cluster_match_score_core_defines.svh"
module track_cluster_match_score_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [tcms_pkg::POS_W-1:0]          cluster_x,
	input  logic [tcms_pkg::POS_W-1:0]          cluster_y,
	input  logic [tcms_pkg::AREA_W-1:0]         cluster_area,
	input  logic [tcms_pkg::ANG_W-1:0]          cluster_angle,
	input  logic [tcms_pkg::POS_W-1:0]          track_x,
	input  logic [tcms_pkg::POS_W-1:0]          track_y,
	input  logic [tcms_pkg::POS_W-1:0]          predicted_x,
	input  logic [tcms_pkg::POS_W-1:0]          predicted_y,
	input  logic [tcms_pkg::AREA_W-1:0]         track_mean_area,
	input  logic [tcms_pkg::ANG_W-1:0]          track_angle,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [tcms_pkg::DIST_W-1:0]         segment_distance,
	output logic [tcms_pkg::AREA_W-1:0]         area_dif,
	output logic [tcms_pkg::FAC_W-1:0]          area_factor,
	output logic signed [tcms_pkg::ANG_W-1:0]   angle_dif,
	output logic [tcms_pkg::FAC_W-1:0]          angle_factor
);
	import tcms_pkg::*;

	localparam int AREA_DLY = CORE_LAT - AREA_LAT;
	localparam int ANG_DLY  = CORE_LAT - ANG_LAT;

	logic                      en;
	logic [CORE_LAT-1:0]       v_s;
	root_req_t                 req;
	logic [AREA_W-1:0]         adif_c;
	logic [FAC_W-1:0]          afac_c, gfac_c;
	logic signed [ANG_W-1:0]   gdif_c;
	logic [AREA_W+FAC_W-1:0]   area_s [AREA_DLY];
	logic [2*FAC_W-1:0]        ang_s  [ANG_DLY];

	assign en       = !(out_valid && out_stall);
	assign in_stall = out_valid && out_stall;
	assign out_valid = v_s[CORE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[CORE_LAT-2:0], in_valid};
		end
	end

	tcms_geom u_geom (
		.clk         (clk),
		.en          (en),
		.cluster_x   (cluster_x),
		.cluster_y   (cluster_y),
		.track_x     (track_x),
		.track_y     (track_y),
		.predicted_x (predicted_x),
		.predicted_y (predicted_y),
		.req         (req)
	);

	tcms_root u_root (
		.clk      (clk),
		.en       (en),
		.req      (req),
		.distance (segment_distance)
	);

	tcms_area u_area (
		.clk             (clk),
		.en              (en),
		.cluster_area    (cluster_area),
		.track_mean_area (track_mean_area),
		.area_dif        (adif_c),
		.area_factor     (afac_c)
	);

	tcms_angle u_angle (
		.clk           (clk),
		.en            (en),
		.cluster_angle (cluster_angle),
		.track_angle   (track_angle),
		.angle_dif     (gdif_c),
		.angle_factor  (gfac_c)
	);

	// align the short paths with the distance result
	always_ff @(posedge clk) begin
		if (en) begin
			area_s[0] <= {adif_c, afac_c};
			for (int i = 1; i < AREA_DLY; i++) begin
				area_s[i] <= area_s[i-1];
			end
			ang_s[0] <= {gdif_c, gfac_c};
			for (int i = 1; i < ANG_DLY; i++) begin
				ang_s[i] <= ang_s[i-1];
			end
		end
	end

	assign area_dif     = area_s[AREA_DLY-1][AREA_W+FAC_W-1:FAC_W];
	assign area_factor  = area_s[AREA_DLY-1][FAC_W-1:0];
	assign angle_dif    = $signed(ang_s[ANG_DLY-1][2*FAC_W-1:FAC_W]);
	assign angle_factor = ang_s[ANG_DLY-1][FAC_W-1:0];

	`TCMS_ASSERT_IMPL(a_area_full, out_valid && area_dif == '0, area_factor == ONE_Q15, "area factor not one at zero difference")
	`TCMS_ASSERT_IMPL(a_angle_full, out_valid, (angle_dif == '0) == (angle_factor == ONE_Q15), "angle factor and difference disagree")
	`TCMS_ASSERT_NEXT(a_bubble, en && !v_s[CORE_LAT-2], !out_valid, "pipeline bubble turned into a result")

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

typedef struct packed {
	logic [15:0] cx, cy;
	logic [19:0] carea;
	logic [15:0] cang;
	logic [15:0] px, py, ex, ey;
	logic [19:0] marea;
	logic [15:0] tang;
} pair_req_t;

typedef struct packed {
	logic [15:0] seg;
	logic [19:0] adif;
	logic [15:0] afac;
	logic signed [15:0] gdif;
	logic [15:0] gfac;
} match_score_t;

class match_scoreboard;
	match_score_t pending[$];
	int errors;

	// round(sqrt(num/den)) halves up, saturated: largest n with (2n-1)^2*den <= 4*num
	static function longint unsigned round_root(logic [127:0] four_num, longint unsigned den);
		longint unsigned lo, hi, mid, odd;
		logic [127:0] prod;
		lo = 0;
		hi = 65535;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			odd = 2 * mid - 1;
			prod = 128'(odd * odd) * 128'(den);
			if (prod <= four_num) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	static function match_score_t score(pair_req_t r);
		match_score_t s;
		longint dx, dy, rx, ry, qx, qy, negdot, crs;
		longint unsigned len2, s1, s2, ref_area, mag;
		logic [127:0] cr2;
		longint d;
		dx = longint'(r.ex) - longint'(r.px);
		dy = longint'(r.ey) - longint'(r.py);
		rx = longint'(r.px) - longint'(r.cx);
		ry = longint'(r.py) - longint'(r.cy);
		qx = longint'(r.ex) - longint'(r.cx);
		qy = longint'(r.ey) - longint'(r.cy);
		len2 = dx * dx + dy * dy;
		negdot = -(rx * dx + ry * dy);
		if (len2 != 0 && negdot >= 0 && longint'(negdot) <= longint'(len2)) begin
			crs = dx * ry - dy * rx;
			if (crs < 0) crs = -crs;
			cr2 = 128'(2 * crs) * 128'(2 * crs);
			s.seg = 16'(round_root(cr2, len2));
		end else begin
			s1 = rx * rx + ry * ry;
			s2 = qx * qx + qy * qy;
			s.seg = 16'(round_root(128'(4) * 128'(s1 < s2 ? s1 : s2), 1));
		end
		s.adif = r.carea > r.marea ? r.carea - r.marea : r.marea - r.carea;
		ref_area = r.marea != 0 ? r.marea : r.carea;
		if (ref_area == 0) s.afac = 16'h8000;
		else if (s.adif >= ref_area) s.afac = 0;
		else s.afac = 16'((((ref_area - s.adif) << 16) + ref_area) / (2 * ref_area));
		d = longint'(r.cang) - longint'(r.tang);
		while (d < -23040) d += 46080;
		while (d > 23040) d -= 46080;
		s.gdif = 16'(d);
		mag = d < 0 ? -d : d;
		s.gfac = 16'(32768 - (mag * 64 + 45) / 90);
		return s;
	endfunction

	function void note_request(pair_req_t r);
		pending = {pending, score(r)};
	endfunction

	function void check_result(match_score_t got);
		match_score_t want;
		if (pending.size() == 0) begin
			$display("unexpected result %h", got);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got.seg !== want.seg) report("segment_distance", got.seg, want.seg);
		if (got.adif !== want.adif) report("area_dif", got.adif, want.adif);
		if (got.afac !== want.afac) report("area_factor", got.afac, want.afac);
		if (got.gdif !== want.gdif) report("angle_dif", got.gdif, want.gdif);
		if (got.gfac !== want.gfac) report("angle_factor", got.gfac, want.gfac);
	endfunction

	function void report(string field, longint got, longint want);
		$display("mismatch %s: got %0d want %0d", field, got, want);
		errors++;
	endfunction
endclass

module tb;
	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic out_valid;
	logic out_stall = 0;
	pair_req_t req = '0;
	match_score_t res;
	logic calm = 0;
	int idle_cnt = 0;
	match_scoreboard sb = new();

	always #5 clk = ~clk;

	track_cluster_match_score_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cluster_x(req.cx), .cluster_y(req.cy), .cluster_area(req.carea),
		.cluster_angle(req.cang), .track_x(req.px), .track_y(req.py),
		.predicted_x(req.ex), .predicted_y(req.ey), .track_mean_area(req.marea),
		.track_angle(req.tang),
		.out_valid(out_valid), .out_stall(out_stall),
		.segment_distance(res.seg), .area_dif(res.adif), .area_factor(res.afac),
		.angle_dif(res.gdif), .angle_factor(res.gfac)
	);

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) sb.note_request(req);
		if (arst_n && out_valid && !out_stall) sb.check_result(res);
	end

	// receiver stalls in bursts
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 15);
				out_stall <= 1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt <= 0;
		else idle_cnt <= idle_cnt + 1;
		if (idle_cnt > 2000) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic [15:0] pick16(int unsigned hi);
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 16'(hi);
			default: return 16'($urandom_range(0, hi));
		endcase
	endfunction

	function automatic logic [19:0] pick_area();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 20'hFFFFF;
			2: return 20'($urandom_range(0, 2000));
			default: return 20'($urandom_range(0, 20'hFFFFF));
		endcase
	endfunction

	function automatic pair_req_t random_pair();
		pair_req_t r;
		r.cx = pick16(65535);
		r.cy = pick16(65535);
		r.px = pick16(65535);
		r.py = pick16(65535);
		if ($urandom_range(0, 2) == 0) begin
			// realistic case: cluster and track positions close together
			r.cx = 16'($urandom_range(0, 4000) + 30000);
			r.cy = 16'($urandom_range(0, 4000) + 30000);
			r.px = 16'($urandom_range(0, 4000) + 30000);
			r.py = 16'($urandom_range(0, 4000) + 30000);
		end
		r.ex = $urandom_range(0, 9) == 0 ? r.px : pick16(65535);
		r.ey = $urandom_range(0, 9) == 0 ? r.py : pick16(65535);
		if ($urandom_range(0, 1)) begin
			r.ex = 16'(r.px + $urandom_range(0, 2000) - 1000);
			r.ey = 16'(r.py + $urandom_range(0, 2000) - 1000);
		end
		r.carea = pick_area();
		r.marea = $urandom_range(0, 2) == 0 ? 20'(r.carea + $urandom_range(0, 200) - 100)
			: pick_area();
		r.cang = $urandom_range(0, 9) == 0 ? 16'($urandom) : pick16(46079);
		r.tang = $urandom_range(0, 9) == 0 ? 16'($urandom) : pick16(46079);
		return r;
	endfunction

	task automatic send(pair_req_t r);
		int n;
		if (!calm && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 15);
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
		req <= r;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_fields(logic [15:0] cx, cy, px, py, ex, ey,
			logic [19:0] ca, ma, logic [15:0] cg, tg);
		pair_req_t r;
		r.cx = cx; r.cy = cy; r.px = px; r.py = py; r.ex = ex; r.ey = ey;
		r.carea = ca; r.marea = ma; r.cang = cg; r.tang = tg;
		send(r);
	endtask

	// in_valid drops and the clock advances before the check, so the last accepted request is already noted
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		int k;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// zero-length segment
		send_fields(100, 200, 500, 500, 500, 500, 0, 0, 0, 0);
		// projection inside, perpendicular distance
		send_fields(800, 300, 0, 0, 1600, 0, 100, 100, 23040, 0);
		// projection outside at both ends
		send_fields(0, 0, 100, 100, 2000, 2000, 100, 0, 0, 23040);
		send_fields(65535, 65535, 0, 0, 100, 100, 0, 100, 46079, 0);
		// distance saturates in the two requests below; the rest are area, angle and position corner cases
		send_fields(0, 0, 65535, 65535, 65535, 65535, 20'hFFFFF, 1, 0, 46079);
		send_fields(0, 65535, 65535, 0, 65535, 0, 1, 20'hFFFFF, 65535, 0);
		send_fields(0, 0, 65535, 0, 0, 65535, 3, 2, 0, 65535);
		send_fields(65535, 65535, 65535, 65535, 0, 0, 20'hFFFFF, 20'hFFFFF, 65535, 65535);
		send_fields(32768, 0, 0, 65535, 65535, 65535, 7, 10, 100, 46000);
		send_fields(1, 1, 0, 0, 2, 2, 15, 10, 23041, 0);
		send_fields(300, 300, 0, 0, 0, 1, 30, 10, 0, 23041);
		drain();
		for (k = 0; k < 850; k++) begin
			if (k == 400) drain();
			if (k == 750) calm = 1;
			send(random_pair());
		end
		drain();
		repeat (30) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end
endmodule

FILE: sim.f
+incdir+src
src/tcms_pkg.sv
src/tcms_geom.sv
src/tcms_root.sv
src/tcms_area.sv
src/tcms_angle.sv
src/track_cluster_match_score_core.sv
test/tb.sv
